FILE: src/urh_pkg.sv
// Package for the undo/redo history ring: request codes, beat structs, defaults.
`default_nettype none
package urh_pkg;

  localparam int unsigned HistoryDepthDef = 64;
  localparam int unsigned CoordW          = 16;
  localparam int unsigned BlockW          = 16;
  localparam int unsigned AvailW          = 7;
  localparam int unsigned CoordsW         = 3 * CoordW;
  localparam int unsigned BlocksW         = 2 * BlockW;

  typedef enum logic [1:0] {
    REQ_RECORD = 2'd0,
    REQ_UNDO   = 2'd1,
    REQ_REDO   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        block_old;
    logic [15:0]        block_new;
  } req_t;

  typedef struct packed {
    logic               write_valid;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic [15:0]        out_block;
    logic [6:0]         undo_avail;
    logic [6:0]         redo_avail;
  } rsp_t;

endpackage
`default_nettype wire

FILE: src/urh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module urh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: src/undo_redo_ring_history_top.sv
// Top level of the undo/redo history ring: counters, ring memories and result register.
// Takes one request per clock cycle (busy_o stays low); the result beat of a request
// appears on rsp_o with valid_o high in the cycle after start_i, for exactly one cycle,
// as set by the registered read of the ring memories. Record writes its entry
// at the accepting edge, so an undo in the very next cycle already sees it. There is no
// clearing pass after reset; the ring contents are only reachable once recorded.
`default_nettype none
module undo_redo_ring_history_top #(
  parameter int unsigned HistoryDepth = urh_pkg::HistoryDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire urh_pkg::req_t req_i,
  output logic             busy_o,
  output logic             valid_o,
  output urh_pkg::rsp_t    rsp_o
);

  localparam int unsigned AW = $clog2(HistoryDepth);
  localparam int unsigned CW = $clog2(HistoryDepth + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [AW-1:0] LastSlot = AW'(HistoryDepth - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(HistoryDepth);
  localparam logic [SW-1:0] DepthS   = SW'(HistoryDepth);

  logic [AW-1:0] tip_q, tip_d;
  logic [CW-1:0] stored_q, stored_d;
  logic [CW-1:0] undone_q, undone_d;

  logic              valid_q;
  logic              wv_q, wv_d;
  logic              redo_sel_q, redo_sel_d;
  logic [6:0]        undo_av_q, redo_av_q;

  logic              accept;
  logic [CW-1:0]     back;
  logic [SW-1:0]     sum;
  logic [AW-1:0]     slot;
  logic [CW-1:0]     stored_rw;
  logic              we, re;
  logic [urh_pkg::CoordsW-1:0] coords_wr, coords_rd;
  logic [urh_pkg::BlocksW-1:0] blocks_wr, blocks_rd;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Slot `back` steps behind the tip, modulo the ring depth (back <= depth when used).
  assign back = (req_i.req_type == urh_pkg::REQ_UNDO) ? undone_q + CW'(1) : undone_q;
  assign sum  = SW'(tip_q) + DepthS - SW'(back);
  assign slot = (sum >= DepthS) ? AW'(sum - DepthS) : AW'(sum);

  assign stored_rw = stored_q - undone_q;

  always_comb begin
    tip_d      = tip_q;
    stored_d   = stored_q;
    undone_d   = undone_q;
    wv_d       = 1'b0;
    redo_sel_d = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    if (accept) begin
      unique case (req_i.req_type)
        urh_pkg::REQ_RECORD: begin
          // pending redo entries are dropped; tip rewinds to the newest committed edit
          we       = 1'b1;
          undone_d = '0;
          tip_d    = (slot == LastSlot) ? '0 : slot + AW'(1);
          stored_d = (stored_rw == FullCnt) ? FullCnt : stored_rw + CW'(1);
        end
        urh_pkg::REQ_UNDO: begin
          if (stored_q > undone_q) begin
            re       = 1'b1;
            wv_d     = 1'b1;
            undone_d = undone_q + CW'(1);
          end
        end
        urh_pkg::REQ_REDO: begin
          if (undone_q != '0) begin
            re         = 1'b1;
            wv_d       = 1'b1;
            redo_sel_d = 1'b1;
            undone_d   = undone_q - CW'(1);
          end
        end
        urh_pkg::REQ_CLEAR: begin
          tip_d    = '0;
          stored_d = '0;
          undone_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tip_q    <= '0;
      stored_q <= '0;
      undone_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      tip_q    <= tip_d;
      stored_q <= stored_d;
      undone_q <= undone_d;
      valid_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      wv_q       <= wv_d;
      redo_sel_q <= redo_sel_d;
      undo_av_q  <= 7'(stored_d - undone_d);
      redo_av_q  <= 7'(undone_d);
    end
  end

  assign coords_wr = {req_i.pos_z, req_i.pos_y, req_i.pos_x};
  assign blocks_wr = {req_i.block_new, req_i.block_old};

  urh_ram #(
    .Width(urh_pkg::CoordsW),
    .Depth(HistoryDepth)
  ) u_coords_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(slot),
    .wdata_i(coords_wr),
    .re_i   (re),
    .raddr_i(slot),
    .rdata_o(coords_rd)
  );

  urh_ram #(
    .Width(urh_pkg::BlocksW),
    .Depth(HistoryDepth)
  ) u_blocks_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(slot),
    .wdata_i(blocks_wr),
    .re_i   (re),
    .raddr_i(slot),
    .rdata_o(blocks_rd)
  );

  always_comb begin
    rsp_o             = '0;
    rsp_o.write_valid = wv_q;
    rsp_o.undo_avail  = undo_av_q;
    rsp_o.redo_avail  = redo_av_q;
    if (wv_q) begin
      rsp_o.out_x     = coords_rd[15:0];
      rsp_o.out_y     = coords_rd[31:16];
      rsp_o.out_z     = coords_rd[47:32];
      rsp_o.out_block = redo_sel_q ? blocks_rd[31:16] : blocks_rd[15:0];
    end
  end

  assign valid_o = valid_q;

  a_undone_le_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    undone_q <= stored_q) else $error("undone count exceeds stored count");

  a_stored_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= FullCnt) else $error("stored count exceeds ring depth");

  a_tip_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tip_q <= LastSlot) else $error("tip pointer outside ring");

  a_one_beat_per_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_o) else $error("request without result beat");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.req_type == urh_pkg::REQ_CLEAR |=> stored_q == '0 && undone_q == '0)
    else $error("clear left history non-empty");

endmodule
`default_nettype wire

FILE: test/tb_undo_redo_ring_history_top.sv
// Testbench for the undo/redo history ring: random request stream checked against a predictor.
`default_nettype none
module tb_undo_redo_ring_history_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HistDepth  = urh_pkg::HistoryDepthDef;
  localparam int unsigned RandItems  = 650;
  localparam int unsigned CycleLimit = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  urh_pkg::req_t req_i = '0;
  logic busy_o;
  logic valid_o;
  urh_pkg::rsp_t rsp_o;

  undo_redo_ring_history_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  always #4 clk_i = ~clk_i;

  urh_pkg::req_t queued_requests[$];
  urh_pkg::rsp_t predicted_replies[$];
  bit mismatch_seen = 1'b0;
  bit req_taken = 1'b0;
  bit steady_run = 1'b0;
  int idle_left = 0;
  int unsigned cycle_cnt = 0;

  // Predictor state: the ring plus tip pointer and the two depth counters.
  logic signed [15:0] ring_x[HistDepth];
  logic signed [15:0] ring_y[HistDepth];
  logic signed [15:0] ring_z[HistDepth];
  logic [15:0]        ring_old[HistDepth];
  logic [15:0]        ring_new[HistDepth];
  int unsigned        hist_tip = 0;
  int unsigned        hist_stored = 0;
  int unsigned        hist_undone = 0;

  // Slot that lies the given number of steps behind the tip, wrapping around the ring.
  function automatic int unsigned ring_slot(int unsigned back);
    return (hist_tip + 2 * HistDepth - back) % HistDepth;
  endfunction

  function automatic urh_pkg::rsp_t apply_edit_request(urh_pkg::req_t rq);
    urh_pkg::rsp_t rs;
    int unsigned idx;
    rs = '0;
    case (rq.req_type)
      urh_pkg::REQ_RECORD: begin
        // pending redo is dropped: tip goes back to the newest committed edit
        if (hist_undone > 0) begin
          hist_stored = hist_stored - hist_undone;
          hist_tip    = ring_slot(hist_undone);
          hist_undone = 0;
        end
        ring_x[hist_tip]   = rq.pos_x;
        ring_y[hist_tip]   = rq.pos_y;
        ring_z[hist_tip]   = rq.pos_z;
        ring_old[hist_tip] = rq.block_old;
        ring_new[hist_tip] = rq.block_new;
        hist_tip = (hist_tip + 1) % HistDepth;
        if (hist_stored < HistDepth) hist_stored++;
      end
      urh_pkg::REQ_UNDO: begin
        if (hist_stored > hist_undone) begin
          idx = ring_slot(hist_undone + 1);
          rs.write_valid = 1'b1;
          rs.out_x = ring_x[idx];
          rs.out_y = ring_y[idx];
          rs.out_z = ring_z[idx];
          rs.out_block = ring_old[idx];
          hist_undone++;
        end
      end
      urh_pkg::REQ_REDO: begin
        if (hist_undone > 0) begin
          idx = ring_slot(hist_undone);
          rs.write_valid = 1'b1;
          rs.out_x = ring_x[idx];
          rs.out_y = ring_y[idx];
          rs.out_z = ring_z[idx];
          rs.out_block = ring_new[idx];
          hist_undone--;
        end
      end
      default: begin
        hist_tip    = 0;
        hist_stored = 0;
        hist_undone = 0;
      end
    endcase
    rs.undo_avail = 7'(hist_stored - hist_undone);
    rs.redo_avail = 7'(hist_undone);
    return rs;
  endfunction

  function automatic urh_pkg::req_t rand_req(urh_pkg::req_type_e op);
    urh_pkg::req_t rq;
    rq.req_type  = op;
    rq.pos_x     = 16'($urandom);
    rq.pos_y     = 16'($urandom);
    rq.pos_z     = 16'($urandom);
    rq.block_old = 16'($urandom);
    rq.block_new = 16'($urandom);
    return rq;
  endfunction

  function automatic urh_pkg::req_type_e pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return urh_pkg::REQ_RECORD;
    if (r < 70) return urh_pkg::REQ_UNDO;
    if (r < 95) return urh_pkg::REQ_REDO;
    return urh_pkg::REQ_CLEAR;
  endfunction

  // Mostly short gaps, a few long ones, and runs of back-to-back beats.
  function automatic int pick_gap();
    int unsigned r;
    if ($urandom_range(0, 49) == 0) steady_run = !steady_run;
    if (steady_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_burst(urh_pkg::req_type_e op, int unsigned len,
                            inout int unsigned total);
    repeat (len) queued_requests.push_back(rand_req(op));
    total += len;
  endtask

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      mismatch_seen = 1'b1;
    end
  endtask

  // Driver: holds the beat until it is taken, then idles or presents the next one.
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !req_taken)) begin
      if (idle_left > 0) begin
        start_i <= 1'b0;
        idle_left--;
      end else if (queued_requests.size() > 0) begin
        start_i <= 1'b1;
        req_i <= queued_requests.pop_front();
        idle_left = pick_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts on every accepted request, then checks the result beat.
  always @(posedge clk_i) begin
    urh_pkg::rsp_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start_i && !busy_o;
      if (start_i && !busy_o) predicted_replies.push_back(apply_edit_request(req_i));
      if ($isunknown(valid_o)) begin
        $display("%0t: valid_o mismatch, expected 0/1, actual %b", $time, valid_o);
        mismatch_seen = 1'b1;
      end else if (valid_o) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, rsp_o);
          mismatch_seen = 1'b1;
        end else begin
          want = predicted_replies.pop_front();
          check_field("write_valid", want.write_valid, rsp_o.write_valid);
          check_field("out_x", want.out_x, rsp_o.out_x);
          check_field("out_y", want.out_y, rsp_o.out_y);
          check_field("out_z", want.out_z, rsp_o.out_z);
          check_field("out_block", want.out_block, rsp_o.out_block);
          check_field("undo_avail", want.undo_avail, rsp_o.undo_avail);
          check_field("redo_avail", want.redo_avail, rsp_o.redo_avail);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned rand_cnt;
    int unsigned pick;
    rand_cnt = 0;

    // directed: empty history, field extremes, redo discard, clear
    queued_requests.push_back(rand_req(urh_pkg::REQ_UNDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_REDO));
    queued_requests.push_back(urh_pkg::req_t'{urh_pkg::REQ_RECORD, 16'h8000, 16'h7FFF,
                                              16'h0000, 16'h0000, 16'hFFFF});
    queued_requests.push_back(urh_pkg::req_t'{urh_pkg::REQ_RECORD, 16'h7FFF, 16'h8000,
                                              16'hFFFF, 16'hFFFF, 16'h0000});
    queued_requests.push_back(urh_pkg::req_t'{urh_pkg::REQ_RECORD, 16'h0000, 16'hFFFF,
                                              16'h7FFF, 16'h5A5A, 16'hA5A5});
    queued_requests.push_back(rand_req(urh_pkg::REQ_UNDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_UNDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_UNDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_UNDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_REDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_REDO));
    queued_requests.push_back(urh_pkg::req_t'{urh_pkg::REQ_RECORD, 16'h8000, 16'h8000,
                                              16'h8000, 16'hFFFF, 16'hFFFF});
    queued_requests.push_back(rand_req(urh_pkg::REQ_REDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_UNDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_CLEAR));
    queued_requests.push_back(rand_req(urh_pkg::REQ_UNDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_REDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_RECORD));
    queued_requests.push_back(rand_req(urh_pkg::REQ_UNDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_REDO));
    queued_requests.push_back(rand_req(urh_pkg::REQ_CLEAR));

    // fill past full depth, then walk all the way back and part way forward
    push_burst(urh_pkg::REQ_RECORD, HistDepth + $urandom_range(3, 20), rand_cnt);
    push_burst(urh_pkg::REQ_UNDO, HistDepth + 2, rand_cnt);
    push_burst(urh_pkg::REQ_REDO, $urandom_range(5, 30), rand_cnt);

    while (rand_cnt < RandItems) begin
      pick = $urandom_range(0, 14);
      if (pick < 4) push_burst(urh_pkg::REQ_RECORD, $urandom_range(5, 80), rand_cnt);
      else if (pick < 7) push_burst(urh_pkg::REQ_UNDO, $urandom_range(1, 70), rand_cnt);
      else if (pick < 9) push_burst(urh_pkg::REQ_REDO, $urandom_range(1, 70), rand_cnt);
      else if (pick == 9) push_burst(urh_pkg::REQ_CLEAR, 1, rand_cnt);
      else begin
        repeat (20) queued_requests.push_back(rand_req(pick_op()));
        rand_cnt += 20;
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (queued_requests.size() != 0 || start_i || predicted_replies.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    if (!mismatch_seen && predicted_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
src/urh_pkg.sv
src/urh_ram.sv
src/undo_redo_ring_history_top.sv
test/tb_undo_redo_ring_history_top.sv
